[rtl/imhq_pkg.sv]
`timescale 1ns / 1ps
package imhq_pkg;

  localparam int unsigned KeyW  = 6;
  localparam int unsigned NumKeys = 64;
  localparam int unsigned PrioInW = 32;
  localparam int unsigned CountOutW = 7;

  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_UPDATE = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2,
    ST_DUP    = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [KeyW-1:0]    key_id;
    logic [PrioInW-1:0] prio_in;
  } in_word_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [KeyW-1:0]      root_key;
    logic [PrioInW-1:0]   root_prio;
    logic                 is_empty;
    logic [CountOutW-1:0] entry_count;
  } out_word_t;

endpackage

[rtl/indexed_min_heap_queue_unit.sv]
`timescale 1ns / 1ps
// Indexed binary min-heap over 64 key IDs.
// Input channel (in_valid_i/in_ready_o/in_word_i) carries an action: push a
// key with a priority, pop the root, or change a present key's priority.
// Output channel (out_valid_o/out_ready_i/out_word_o) returns one word per
// input word: status, root key and priority, empty flag and entry count.
// Heap slots live in one single-port memory with a registered read; a small
// sequencer walks the heap one level at a time, reading a parent or children,
// comparing in one shared comparator and writing back a swap.
// A rejected or no-op action passes S_CHECK, S_ROOT and S_ROOTW. Each sift level
// runs S_RDB, S_CMP, S_WRA, S_WRB going up and S_RDB, S_RDC, S_CMP, S_WRA, S_WRB
// going down (S_CMP is skipped with only a left child). in_ready_o rises as the
// result is loaded into the output register; the block takes one word at a time.
// The result sits in an output register and holds while the receiver stalls;
// the next word is still taken and worked on, then waits for the register.
// Reset clears the fill count and the per-key position valid bits (flip-flops);
// positions live in a small memory, so the heap starts empty with no clearing pass.
module indexed_min_heap_queue_unit #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned PRIO_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  imhq_pkg::in_word_t in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output imhq_pkg::out_word_t out_word_o
);
  import imhq_pkg::*;

  localparam int unsigned SW = $clog2(CAPACITY + 1);   // slot index / count width
  localparam int unsigned PW = PRIO_WIDTH;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CHECK = 11'b00000000010,
    S_RDA   = 11'b00000000100,  // read slot at
    S_RDB   = 11'b00000001000,  // read parent or left child
    S_RDC   = 11'b00000010000,  // read right child
    S_CMP   = 11'b00000100000,
    S_WRA   = 11'b00001000000,  // write at <- other
    S_WRB   = 11'b00010000000,  // write other <- at
    S_POPRD = 11'b00100000000,  // read last slot
    S_ROOT  = 11'b01000000000,  // read root for output
    S_ROOTW = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  // slot memory, key and priority together
  logic [KeyW+PW-1:0] mem [CAPACITY+1];
  logic               mem_we;
  logic [SW-1:0]      mem_addr;
  logic [KeyW+PW-1:0] mem_wdata, mem_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata_q <= mem[mem_addr];
  end

  // key position memory; a key reads as absent until its entry is written
  logic [SW-1:0]      pos_mem [NumKeys];
  logic [NumKeys-1:0] pos_vld_q;
  logic               pos_we;
  logic [KeyW-1:0]    pos_wkey;
  logic [SW-1:0]      pos_wval;
  logic [KeyW-1:0]    pos_raddr;
  logic [SW-1:0]      pos_rdata_q;
  logic               pos_rvld_q;
  logic [SW-1:0]      pos_at;

  logic [SW-1:0]   cnt_q, cnt_d;
  logic [1:0]      act_q;
  logic [KeyW-1:0] key_q;
  logic [PW-1:0]   prio_q;

  // look up the incoming key while idle, the held key otherwise
  assign pos_raddr = in_ready_o ? in_word_i.key_id : key_q;

  always_ff @(posedge clk_i) begin
    if (pos_we) begin
      pos_mem[pos_wkey] <= pos_wval;
    end
    pos_rdata_q <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_vld_q  <= '0;
      pos_rvld_q <= 1'b0;
    end else begin
      if (pos_we) pos_vld_q[pos_wkey] <= 1'b1;
      pos_rvld_q <= pos_vld_q[pos_raddr];
    end
  end

  assign pos_at = pos_rvld_q ? pos_rdata_q : '0;

  logic [1:0]      stat_q, stat_d;
  logic            dn_q, dn_d;         // sift direction: 1 = down
  logic [SW-1:0]   at_q, at_d, oth_q, oth_d;
  logic [KeyW-1:0] ak_q, ak_d, bk_q, bk_d;
  logic [PW-1:0]   ap_q, ap_d, bp_q, bp_d;
  logic            cv_q, cv_d;         // right child exists
  out_word_t       out_q, out_d;
  logic            ov_q, ov_d;

  logic [SW:0] left_w;
  assign left_w = {at_q, 1'b0};

  logic [KeyW-1:0] rk;
  logic [PW-1:0]   rp;
  assign rk = mem_rdata_q[KeyW+PW-1:PW];
  assign rp = mem_rdata_q[PW-1:0];

  // shared comparator
  logic [PW-1:0] cmp_a, cmp_b;
  logic          lt;
  assign lt = cmp_a < cmp_b;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q; stat_d = stat_q; dn_d = dn_q;
    at_d = at_q; oth_d = oth_q;
    ak_d = ak_q; ap_d = ap_q; bk_d = bk_q; bp_d = bp_q;
    cv_d = cv_q;
    out_d = out_q; ov_d = ov_q;
    mem_we = 1'b0; mem_addr = at_q; mem_wdata = {ak_q, ap_q};
    pos_we = 1'b0; pos_wkey = key_q; pos_wval = '0;
    cmp_a = ap_q; cmp_b = bp_q;

    if (ov_q && out_ready_i) ov_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        stat_d = ST_DONE;
        state_d = S_ROOT;
        case (act_q)
          ACT_PUSH: begin
            if (cnt_q >= SW'(CAPACITY)) stat_d = ST_FULL;
            else if (pos_at != '0) stat_d = ST_DUP;
            else begin
              cnt_d = cnt_q + 1'b1;
              mem_we = 1'b1; mem_addr = cnt_q + 1'b1;
              mem_wdata = {key_q, prio_q};
              pos_we = 1'b1; pos_wval = cnt_q + 1'b1;
              at_d = cnt_q + 1'b1; ak_d = key_q; ap_d = prio_q;
              dn_d = 1'b0;
              state_d = S_RDB;
            end
          end
          ACT_POP: begin
            if (cnt_q == '0) stat_d = ST_FULL;
            else begin
              // drop current root key: read root first
              mem_addr = SW'(1);
              state_d = S_POPRD;
              at_d = '0;
            end
          end
          ACT_UPDATE: begin
            if (pos_at == '0 || pos_at > cnt_q) stat_d = ST_ABSENT;
            else begin
              at_d = pos_at;
              mem_addr = pos_at;
              state_d = S_RDA;
            end
          end
          default: ;
        endcase
      end
      S_POPRD: begin
        if (at_q == '0) begin
          // root data arrived: clear its key, fetch last slot
          pos_we = 1'b1; pos_wkey = rk; pos_wval = '0;
          if (cnt_q == SW'(1)) begin
            cnt_d = '0;
            state_d = S_ROOT;
          end else begin
            mem_addr = cnt_q;
            at_d = SW'(1);
          end
        end else begin
          // last slot arrived: place at root
          mem_we = 1'b1; mem_addr = SW'(1); mem_wdata = mem_rdata_q;
          pos_we = 1'b1; pos_wkey = rk; pos_wval = SW'(1);
          ak_d = rk; ap_d = rp;
          cnt_d = cnt_q - 1'b1;
          dn_d = 1'b1;
          state_d = S_RDB;
        end
      end
      S_RDA: begin
        // old priority of the updated slot
        cmp_a = prio_q; cmp_b = rp;
        dn_d = !lt;
        ak_d = rk; ap_d = prio_q;
        mem_we = 1'b1; mem_wdata = {rk, prio_q};
        state_d = S_RDB;
      end
      S_RDB: begin
        if (!dn_q) begin
          if (at_q <= SW'(1)) state_d = S_ROOT;
          else begin
            oth_d = at_q >> 1;
            mem_addr = at_q >> 1;
            state_d = S_CMP;
          end
        end else begin
          if (left_w > {1'b0, cnt_q}) state_d = S_ROOT;
          else begin
            oth_d = left_w[SW-1:0];
            mem_addr = left_w[SW-1:0];
            cv_d = (left_w + 1'b1) <= {1'b0, cnt_q};
            state_d = S_RDC;
          end
        end
      end
      S_RDC: begin
        bk_d = rk; bp_d = rp;
        if (cv_q) begin
          mem_addr = oth_q + 1'b1;
          state_d = S_CMP;
        end else begin
          state_d = S_WRA;
          cmp_a = rp; cmp_b = ap_q;
          if (!lt) state_d = S_ROOT;
        end
      end
      S_CMP: begin
        if (!dn_q) begin
          bk_d = rk; bp_d = rp;
          cmp_a = ap_q; cmp_b = rp;
          state_d = lt ? S_WRA : S_ROOT;
        end else begin
          // pick right only if strictly smaller than left
          cmp_a = rp; cmp_b = bp_q;
          if (lt) begin
            bk_d = rk; bp_d = rp; oth_d = oth_q + 1'b1;
          end
          state_d = S_WRA;
        end
      end
      S_WRA: begin
        // down path still has to check best against at
        cmp_a = bp_q; cmp_b = ap_q;
        if (dn_q && !lt) state_d = S_ROOT;
        else begin
          mem_we = 1'b1; mem_addr = at_q; mem_wdata = {bk_q, bp_q};
          pos_we = 1'b1; pos_wkey = bk_q; pos_wval = at_q;
          state_d = S_WRB;
        end
      end
      S_WRB: begin
        mem_we = 1'b1; mem_addr = oth_q; mem_wdata = {ak_q, ap_q};
        pos_we = 1'b1; pos_wkey = ak_q; pos_wval = oth_q;
        at_d = oth_q;
        state_d = S_RDB;
      end
      S_ROOT: begin
        mem_addr = SW'(1);
        state_d = S_ROOTW;
      end
      S_ROOTW: begin
        // keep the root on the read port until the output register frees
        mem_addr = SW'(1);
        if (!ov_q || out_ready_i) begin
          out_d.status = stat_q;
          out_d.is_empty = (cnt_q == '0);
          out_d.entry_count = CountOutW'(cnt_q);
          out_d.root_key = (cnt_q == '0) ? '0 : rk;
          out_d.root_prio = (cnt_q == '0) ? '0 : PrioInW'(rp);
          ov_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ov_q;
  assign out_word_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      act_q  <= in_word_i.action;
      key_q  <= in_word_i.key_id;
      prio_q <= PW'(in_word_i.prio_in);
    end
    stat_q <= stat_d; dn_q <= dn_d;
    at_q <= at_d; oth_q <= oth_d;
    ak_q <= ak_d; ap_q <= ap_d; bk_q <= bk_d; bp_q <= bp_d;
    cv_q <= cv_d;
    out_q <= out_d;
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= SW'(CAPACITY)) else $error("count over capacity");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != $past(cnt_q) |-> (cnt_q == $past(cnt_q) + 1'b1 ||
      cnt_q == $past(cnt_q) - 1'b1 || cnt_q == '0)) else $error("count jump");
  a_ready_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("output dropped");
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.is_empty |-> out_word_o.entry_count == '0)
    else $error("empty flag mismatch");
endmodule

[sim/indexed_min_heap_queue_unit_tb.sv]
`timescale 1ns / 1ps
module indexed_min_heap_queue_unit_tb;
  import imhq_pkg::*;

  localparam int unsigned Cap = 64;
  localparam int unsigned WatchLimit = 4000;
  localparam int unsigned RandWords = 2000;
  localparam int unsigned ExpDepth = 16;
  localparam int unsigned RowMax = 32;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_word_t out_word_o;

  indexed_min_heap_queue_unit uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_word_i(in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o(out_word_o)
  );

  // heap mirror: slots 1..heap_fill, key_slot 0 means absent
  logic [KeyW-1:0]    heap_key [1:Cap];
  logic [PrioInW-1:0] heap_prio [1:Cap];
  int unsigned        key_slot [NumKeys];
  int unsigned        heap_fill;

  // expected words in order, written at input acceptance
  out_word_t   exp_mem [ExpDepth];
  int unsigned exp_wr;
  int unsigned exp_rd;
  int unsigned mismatches;
  int unsigned idle_cycles;

  // typed expectation travels with the word being offered
  bit        row_typed;
  out_word_t row_want;

  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t result;
  } stim_row_t;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [KeyW-1:0]    k;
    logic [PrioInW-1:0] p;
    k = heap_key[a];
    p = heap_prio[a];
    heap_key[a] = heap_key[b];
    heap_prio[a] = heap_prio[b];
    heap_key[b] = k;
    heap_prio[b] = p;
    key_slot[heap_key[a]] = a;
    key_slot[heap_key[b]] = b;
  endfunction

  function automatic void bubble_up(int unsigned at);
    while (at > 1 && heap_prio[at] < heap_prio[at / 2]) begin
      swap_slots(at, at / 2);
      at = at / 2;
    end
  endfunction

  function automatic void bubble_down(int unsigned at);
    int unsigned best;
    forever begin
      best = at;
      if (2 * at <= heap_fill && heap_prio[2 * at] < heap_prio[best]) best = 2 * at;
      if (2 * at + 1 <= heap_fill && heap_prio[2 * at + 1] < heap_prio[best]) best = 2 * at + 1;
      if (best == at) return;
      swap_slots(at, best);
      at = best;
    end
  endfunction

  function automatic out_word_t apply_heap_action(in_word_t w);
    out_word_t   r;
    status_e     st;
    int unsigned at;
    logic [PrioInW-1:0] old;
    st = ST_DONE;
    case (action_e'(w.action))
      ACT_PUSH: begin
        if (heap_fill >= Cap) st = ST_FULL;
        else if (key_slot[w.key_id] != 0) st = ST_DUP;
        else begin
          heap_fill++;
          heap_key[heap_fill] = w.key_id;
          heap_prio[heap_fill] = w.prio_in;
          key_slot[w.key_id] = heap_fill;
          bubble_up(heap_fill);
        end
      end
      ACT_POP: begin
        if (heap_fill == 0) st = ST_FULL;
        else begin
          key_slot[heap_key[1]] = 0;
          if (heap_fill > 1) begin
            heap_key[1] = heap_key[heap_fill];
            heap_prio[1] = heap_prio[heap_fill];
            heap_fill--;
            key_slot[heap_key[1]] = 1;
            bubble_down(1);
          end else begin
            heap_fill = 0;
          end
        end
      end
      ACT_UPDATE: begin
        at = key_slot[w.key_id];
        if (at == 0 || at > heap_fill) st = ST_ABSENT;
        else begin
          old = heap_prio[at];
          heap_prio[at] = w.prio_in;
          if (w.prio_in < old) bubble_up(at);
          else bubble_down(at);
        end
      end
      default: ;
    endcase
    r.status = st;
    r.root_key = heap_fill > 0 ? heap_key[1] : '0;
    r.root_prio = heap_fill > 0 ? heap_prio[1] : '0;
    r.is_empty = heap_fill == 0;
    r.entry_count = heap_fill[CountOutW-1:0];
    return r;
  endfunction

  task automatic send_word(in_word_t w, bit typed = 1'b0, out_word_t want = '0);
    int unsigned gap;
    gap = $urandom_range(0, 18);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    row_typed <= typed;
    row_want <= want;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // drop valid before the sender pauses
  task automatic end_input();
    in_valid_i <= 1'b0;
  endtask

  function automatic in_word_t make_word(action_e a, int unsigned k, logic [PrioInW-1:0] p);
    in_word_t w;
    w.action = a;
    w.key_id = k[KeyW-1:0];
    w.prio_in = p;
    return w;
  endfunction

  // predict at acceptance, so the order follows the block's order
  always @(posedge clk_i) begin
    out_word_t pred;
    if (rst_ni && in_valid_i && in_ready_o) begin
      pred = apply_heap_action(in_word_i);
      exp_mem[exp_wr % ExpDepth] = row_typed ? row_want : pred;
      exp_wr++;
    end
  end

  // receiver: random stall per word, compare on each accepted word
  initial begin
    int unsigned stall;
    out_word_t   want;
    out_ready_i = 1'b0;
    mismatches = 0;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, 18);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (exp_wr == exp_rd) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %p", out_word_o);
      end else begin
        want = exp_mem[exp_rd % ExpDepth];
        exp_rd++;
        if (out_word_o !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, actual %p", want, out_word_o);
        end
      end
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  stim_row_t   rows [RowMax];
  int unsigned row_count;

  task automatic add_row(action_e a, int unsigned k, logic [PrioInW-1:0] p,
                         bit typed = 1'b0, out_word_t r = '0);
    stim_row_t s;
    s.word = make_word(a, k, p);
    s.typed = typed;
    s.result = r;
    rows[row_count] = s;
    row_count++;
  endtask

  function automatic out_word_t typed_result(status_e st, int unsigned k,
                                             logic [PrioInW-1:0] p, int unsigned n);
    out_word_t r;
    r.status = st;
    r.root_key = k[KeyW-1:0];
    r.root_prio = p;
    r.is_empty = n == 0;
    r.entry_count = n[CountOutW-1:0];
    return r;
  endfunction

  initial begin
    int unsigned k;
    int unsigned pick;
    logic [PrioInW-1:0] p;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_word_i = '0;
    row_typed = 1'b0;
    row_want = '0;
    exp_wr = 0;
    exp_rd = 0;
    row_count = 0;
    heap_fill = 0;
    foreach (key_slot[i]) key_slot[i] = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    add_row(ACT_POP, 0, '0, 1'b1, typed_result(ST_FULL, 0, '0, 0));
    add_row(ACT_UPDATE, 63, '1, 1'b1, typed_result(ST_ABSENT, 0, '0, 0));
    add_row(ACT_NONE, 63, '1, 1'b1, typed_result(ST_DONE, 0, '0, 0));
    add_row(ACT_PUSH, 63, '1, 1'b1, typed_result(ST_DONE, 63, '1, 1));
    add_row(ACT_PUSH, 63, 5, 1'b1, typed_result(ST_DUP, 63, '1, 1));
    add_row(ACT_PUSH, 0, '0, 1'b1, typed_result(ST_DONE, 0, '0, 2));
    add_row(ACT_PUSH, 21, 32'h5555_5555);
    add_row(ACT_PUSH, 42, 32'hAAAA_AAAA);
    add_row(ACT_PUSH, 7, 32'h5555_5555);
    add_row(ACT_UPDATE, 21, 32'h5555_5555);
    add_row(ACT_UPDATE, 42, 32'h0000_0001);
    add_row(ACT_UPDATE, 0, 32'hFFFF_FFFE);
    add_row(ACT_POP, 0, '0);
    add_row(ACT_POP, 0, '0);
    add_row(ACT_POP, 0, '0);
    add_row(ACT_POP, 0, '0);
    add_row(ACT_POP, 0, '0, 1'b1, typed_result(ST_DONE, 0, '0, 0));
    add_row(ACT_POP, 0, '0, 1'b1, typed_result(ST_FULL, 0, '0, 0));
    for (int i = 0; i < row_count; i++) begin
      send_word(rows[i].word, rows[i].typed, rows[i].result);
    end

    // fill to capacity with equal priorities, then reject a push on a full heap
    for (int i = 0; i < Cap; i++) send_word(make_word(ACT_PUSH, i, 32'd100));
    send_word(make_word(ACT_PUSH, 5, 32'd1));
    end_input();
    wait (exp_wr == exp_rd);
    for (int i = 0; i < Cap; i++) send_word(make_word(ACT_POP, 0, '0));

    // random: valid keys, mostly push/pop/update actions, with a pause to drain halfway
    for (int n = 0; n < RandWords; n++) begin
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, 63);
      case ($urandom_range(0, 3))
        0: p = $urandom();
        1: p = $urandom_range(0, 7);
        2: p = '1 - $urandom_range(0, 3);
        default: p = $urandom_range(0, 1000);
      endcase
      if (pick < 45) send_word(make_word(ACT_PUSH, k, p));
      else if (pick < 70) send_word(make_word(ACT_POP, k, p));
      else if (pick < 97) send_word(make_word(ACT_UPDATE, k, p));
      else send_word(make_word(ACT_NONE, k, p));
      if (n == RandWords / 2) begin
        end_input();
        wait (exp_wr == exp_rd);
      end
    end
    end_input();
    wait (exp_wr == exp_rd);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && exp_wr == exp_rd) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
